@@ sv/dqs_pkg.sv @@
// Package for the double-ended queue with search: request/response types and codes.
`default_nettype none

package dqs_pkg;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Input item
    typedef struct packed {
        logic        [2:0]  req_type;
        logic signed [31:0] item_value;
    } t_req;

    // Result item
    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] popped_value;
        logic        [3:0]  match_position;
        logic        [4:0]  item_count;
    } t_rsp;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic shift_back;   // take the entry of the cell in front
        logic shift_fwd;    // take the entry of the cell behind
        logic lane_load;    // copy the entry into the scan lane
        logic lane_shift;   // take the scan lane of the cell behind
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/dqs_cell.sv @@
// One storage cell of the queue chain: an entry register and a scan lane register.
`default_nettype none

module dqs_cell (
    input  wire                    i_clk,
    input  wire dqs_pkg::t_cell_ctl i_ctl,
    input  wire                    i_wr,
    input  wire signed [31:0]      i_wr_value,
    input  wire signed [31:0]      i_prev,
    input  wire signed [31:0]      i_next,
    input  wire signed [31:0]      i_next_lane,
    output logic signed [31:0]     o_value,
    output logic signed [31:0]     o_lane
);

    logic signed [31:0] r_value;
    logic signed [31:0] r_lane;

    // Move the entry along the chain or load it in place
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_back) begin
            r_value <= i_prev;
        end else if (i_ctl.shift_fwd) begin
            r_value <= i_next;
        end else if (i_wr) begin
            r_value <= i_wr_value;
        end
    end

    // Copy entries into the scan lane, then advance it toward the front
    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_load) begin
            r_lane <= r_value;
        end else if (i_ctl.lane_shift) begin
            r_lane <= i_next_lane;
        end
    end

    assign o_value = r_value;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

@@ sv/double_ended_queue_with_search.sv @@
// Double-ended queue with search, built as a chain of storage cells.
// Requests are registered in the idle state; push front, push back, pop front and unused codes
// write their result in the exec state; pop back and search first scan, the scan lane moving one
// cell toward the front per cycle. Every result waits for a free output slot.
// Throughput: one item at a time; the next input transfer follows the result write.
// Reset clears the occupancy and the output valid; cell entries stay undefined.
`default_nettype none

module double_ended_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire dqs_pkg::t_req i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output dqs_pkg::t_rsp    o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    t_state            r_state, n_state;
    dqs_pkg::t_req     r_req, n_req;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx, n_idx;
    dqs_pkg::t_rsp     r_out, n_out;
    logic              r_out_valid, n_out_valid;

    dqs_pkg::t_cell_ctl w_ctl;
    dqs_pkg::t_rsp      w_rsp;
    logic               w_rsp_we;
    logic               w_slot_free;
    logic               w_full;
    logic               w_empty;
    logic               w_hit;
    logic               w_last;
    logic [CW-1:0]      w_count_m1;
    logic signed [31:0] w_val  [DEPTH];
    logic signed [31:0] w_lane [DEPTH];

    // Cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [31:0] w_prev;
        logic signed [31:0] w_next;
        logic signed [31:0] w_next_lane;
        logic               w_wr;

        if (gi == 0) begin : g_head
            assign w_prev = r_req.item_value;
        end else begin : g_mid
            assign w_prev = w_val[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next      = w_val[gi];
            assign w_next_lane = w_lane[gi];
        end else begin : g_body
            assign w_next      = w_val[gi+1];
            assign w_next_lane = w_lane[gi+1];
        end

        // Push back writes the cell just past the last entry
        assign w_wr = (r_state == ST_EXEC) && w_slot_free && !w_full
                    && (r_req.req_type == dqs_pkg::REQ_PUSH_BACK)
                    && (r_count == CW'(gi));

        dqs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_wr        (w_wr),
            .i_wr_value  (r_req.item_value),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_next_lane (w_next_lane),
            .o_value     (w_val[gi]),
            .o_lane      (w_lane[gi])
        );
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_count_m1  = r_count - 1'b1;
    assign w_hit       = (r_req.req_type == dqs_pkg::REQ_SEARCH)
                       && (w_lane[0] == r_req.item_value);
    assign w_last      = (r_idx == IW'(w_count_m1));

    // Sequence one request and build its result
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_idx    = r_idx;
        w_ctl    = '0;
        w_rsp    = '0;
        w_rsp_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_slot_free) begin
                    w_rsp_we = 1'b1;
                    n_state  = ST_IDLE;
                    unique case (r_req.req_type) inside
                        dqs_pkg::REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                w_rsp.status = dqs_pkg::ST_FULL;
                            end else begin
                                w_ctl.shift_back = 1'b1;
                                n_count          = r_count + 1'b1;
                            end
                        end
                        dqs_pkg::REQ_PUSH_BACK: begin
                            if (w_full) begin
                                w_rsp.status = dqs_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        dqs_pkg::REQ_POP_FRONT: begin
                            if (w_empty) begin
                                w_rsp.status = dqs_pkg::ST_EMPTY;
                            end else begin
                                w_rsp.popped_value = w_val[0];
                                w_ctl.shift_fwd    = 1'b1;
                                n_count            = w_count_m1;
                            end
                        end
                        dqs_pkg::REQ_POP_BACK, dqs_pkg::REQ_SEARCH: begin
                            if (w_empty) begin
                                w_rsp.status = (r_req.req_type == dqs_pkg::REQ_SEARCH)
                                             ? dqs_pkg::ST_NOT_FOUND : dqs_pkg::ST_EMPTY;
                            end else begin
                                // Start the scan from the front entry
                                w_rsp_we        = 1'b0;
                                w_ctl.lane_load = 1'b1;
                                n_idx           = '0;
                                n_state         = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_hit || w_last) begin
                    // Finish once the output slot can take the result
                    if (w_slot_free) begin
                        w_rsp_we = 1'b1;
                        n_state  = ST_IDLE;
                        if (r_req.req_type == dqs_pkg::REQ_SEARCH) begin
                            if (w_hit) begin
                                w_rsp.match_position = 4'(r_idx);
                            end else begin
                                w_rsp.status = dqs_pkg::ST_NOT_FOUND;
                            end
                        end else begin
                            w_rsp.popped_value = w_lane[0];
                            n_count            = w_count_m1;
                        end
                    end
                end else begin
                    w_ctl.lane_shift = 1'b1;
                    n_idx            = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_rsp.item_count = 5'(n_count);
    end

    // Output register: load a finished result, drop it after the transfer
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_rsp_we) begin
            n_out       = w_rsp;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Occupancy never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    // A scan runs only over a non-empty store
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("scan on empty store");

    // The scan position stays inside the held entries
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("scan index past last entry");

    // A pending full result means the store is still full
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == dqs_pkg::ST_FULL)) |-> w_full)
        else $error("full status with free space");

endmodule

`default_nettype wire

@@ tb/sv/dqs_checker.sv @@
// Checker for the double-ended queue with search: predicts and compares every result.
`timescale 1ns / 100ps

module dqs_checker #(
    parameter int DEPTH = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_in_stall,
    input  dqs_pkg::t_req i_in_data,
    input  wire           i_out_valid,
    input  wire           i_out_stall,
    input  dqs_pkg::t_rsp i_out_data,
    output int            o_fail_count,
    output int            o_pending_count,
    output int            o_checked_count,
    output int            o_status_hits [4]
);

    // Predicted contents of the queue, front entry at index 0
    logic signed [31:0] queue_image [DEPTH];
    int unsigned        queue_fill;

    dqs_pkg::t_rsp expected_results [$];
    int            mismatches;
    int            checked;
    int            status_seen [4];

    // Apply one request to the predicted queue and return its result
    function automatic dqs_pkg::t_rsp predict_request(input dqs_pkg::t_req req);
        dqs_pkg::t_rsp rsp;
        logic          found;
        int unsigned   hit_index;
        rsp       = '0;
        found     = 1'b0;
        hit_index = 0;
        case (req.req_type)
            dqs_pkg::REQ_PUSH_FRONT: begin
                if (queue_fill >= DEPTH) begin
                    rsp.status = dqs_pkg::ST_FULL;
                end else begin
                    for (int i = int'(queue_fill); i > 0; i--)
                        queue_image[i] = queue_image[i - 1];
                    queue_image[0] = req.item_value;
                    queue_fill++;
                end
            end
            dqs_pkg::REQ_PUSH_BACK: begin
                if (queue_fill >= DEPTH) begin
                    rsp.status = dqs_pkg::ST_FULL;
                end else begin
                    queue_image[queue_fill] = req.item_value;
                    queue_fill++;
                end
            end
            dqs_pkg::REQ_POP_FRONT: begin
                if (queue_fill == 0) begin
                    rsp.status = dqs_pkg::ST_EMPTY;
                end else begin
                    rsp.popped_value = queue_image[0];
                    for (int i = 1; i < int'(queue_fill); i++)
                        queue_image[i - 1] = queue_image[i];
                    queue_fill--;
                end
            end
            dqs_pkg::REQ_POP_BACK: begin
                if (queue_fill == 0) begin
                    rsp.status = dqs_pkg::ST_EMPTY;
                end else begin
                    queue_fill--;
                    rsp.popped_value = queue_image[queue_fill];
                end
            end
            dqs_pkg::REQ_SEARCH: begin
                // First match counted from the front wins
                for (int i = 0; i < int'(queue_fill); i++) begin
                    if (!found && queue_image[i] == req.item_value) begin
                        found     = 1'b1;
                        hit_index = i;
                    end
                end
                if (found)
                    rsp.match_position = 4'(hit_index);
                else
                    rsp.status = dqs_pkg::ST_NOT_FOUND;
            end
            default: begin
                // Unused codes leave the queue alone
            end
        endcase
        rsp.item_count = 5'(queue_fill);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        dqs_pkg::t_rsp want;
        if (!i_rst_n) begin
            queue_fill = 0;
            expected_results.delete();
            mismatches = 0;
            checked    = 0;
            for (int s = 0; s < 4; s++)
                status_seen[s] = 0;
        end else begin
            // Predict on every input transfer
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_request(i_in_data));

            // Compare every output transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: status %0d popped %0d %s %0d %s %0d",
                                 $realtime, i_out_data.status, i_out_data.popped_value,
                                 "pos", i_out_data.match_position,
                                 "count", i_out_data.item_count);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    status_seen[want.status]++;
                    if (i_out_data.status !== want.status ||
                        i_out_data.popped_value !== want.popped_value ||
                        i_out_data.match_position !== want.match_position ||
                        i_out_data.item_count !== want.item_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("[%0t] mismatch: expected status %0d popped %0d pos %0d ",
                                   $realtime, want.status, want.popped_value,
                                   want.match_position);
                            $display("count %0d, got status %0d popped %0d pos %0d count %0d",
                                     want.item_count,
                                     i_out_data.status, i_out_data.popped_value,
                                     i_out_data.match_position, i_out_data.item_count);
                        end
                    end
                end
            end
        end

        // Publish counters once per cycle
        o_fail_count    <= mismatches;
        o_pending_count <= expected_results.size();
        o_checked_count <= checked;
        for (int s = 0; s < 4; s++)
            o_status_hits[s] <= status_seen[s];
    end

endmodule

@@ tb/sv/double_ended_queue_with_search_test.sv @@
// Top of the double-ended queue with search testbench: stimulus, idling and verdict.
`timescale 1ns / 100ps

module double_ended_queue_with_search_test;

    localparam int DEPTH          = 16;
    localparam int IDLE_PCT       = 9;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;

    // Codes the block treats as no operation
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_stall;
    dqs_pkg::t_req in_data;
    logic          out_valid;
    logic          out_stall;
    dqs_pkg::t_rsp out_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int status_hits [4];

    logic               sender_gaps_on;
    logic               receiver_stalls_on;
    int                 holdoff_requests;
    int                 sent_per_code [8];
    int                 idle_cycles;
    logic signed [31:0] value_pool [8];

    double_ended_queue_with_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    dqs_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count),
        .o_checked_count(checked_count),
        .o_status_hits  (status_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
            $display("double_ended_queue_with_search regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int served;
        served = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_requests > served) begin
                served++;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else begin
                out_stall <= receiver_stalls_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one request, with an optional random gap first, and hold until transfer
    task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
        while (sender_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: code, item_value: value};
        do
            @(posedge i_clk);
        while (in_stall);
        sent_per_code[code]++;
    endtask

    // Mostly pool values so searches hit, some extremes, some fully random
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return value_pool[$urandom_range(7)];
        if (r < 68) begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_code(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        if (r < 23)
            return dqs_pkg::REQ_SEARCH;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? dqs_pkg::REQ_PUSH_BACK : dqs_pkg::REQ_PUSH_FRONT;
        return $urandom_range(1) ? dqs_pkg::REQ_POP_BACK : dqs_pkg::REQ_POP_FRONT;
    endfunction

    // Random traffic in bursts that lean toward filling or draining the queue
    task automatic run_random(input int n_items);
        int         done;
        int         push_pct;
        logic [2:0] code;
        done     = 0;
        push_pct = 50;
        while (done < n_items) begin
            if ($urandom_range(39) == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            code = pick_code(push_pct);
            send_request(code, pick_value());
            if (code <= dqs_pkg::REQ_SEARCH)
                done++;
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        holdoff_requests   = 0;
        for (int k = 0; k < 8; k++) begin
            sent_per_code[k] = 0;
            value_pool[k]    = $urandom;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store cases, no idling on either side
        send_request(dqs_pkg::REQ_POP_FRONT, VAL_MAX);
        send_request(dqs_pkg::REQ_POP_BACK, VAL_MIN);
        send_request(dqs_pkg::REQ_SEARCH, 32'sd0);
        send_request(REQ_UNUSED_LAST, -32'sd1);

        // Extremes at both ends, then a duplicate to check first-match order
        send_request(dqs_pkg::REQ_PUSH_FRONT, VAL_MIN);
        send_request(dqs_pkg::REQ_PUSH_BACK, VAL_MAX);
        send_request(dqs_pkg::REQ_PUSH_BACK, -32'sd1);
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'sd0);
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'sd0);
        send_request(dqs_pkg::REQ_SEARCH, 32'sd0);
        send_request(dqs_pkg::REQ_SEARCH, -32'sd1);
        send_request(dqs_pkg::REQ_SEARCH, 32'sd1);

        // Fill to the top, then push into a full store from both ends
        for (int k = 0; k < DEPTH - 5; k++)
            send_request(dqs_pkg::REQ_PUSH_BACK,
                         (k[0] ? 32'shAAAA_AAAA : 32'sh5555_5555) ^ k);
        send_request(dqs_pkg::REQ_PUSH_FRONT, VAL_MAX);
        send_request(dqs_pkg::REQ_PUSH_BACK, VAL_MIN);
        send_request(dqs_pkg::REQ_SEARCH, 32'sh5555_5555 ^ (DEPTH - 6));
        send_request(REQ_UNUSED_FIRST, VAL_MAX);
        send_request(dqs_pkg::REQ_POP_FRONT, 32'sd0);
        send_request(dqs_pkg::REQ_POP_BACK, 32'sd0);

        // Random traffic with idling on both sides
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        run_random(300);

        // Hold the receiver off while requests keep coming
        holdoff_requests++;
        run_random(60);

        // Pause the sender until every result is back
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);

        // Back-to-back stretch, then idling again
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        run_random(150);
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        run_random(390);
        in_valid <= 1'b0;

        // Drain
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d push front, %0d push back, %0d pop front, %0d pop back, %s %0d",
                 sent_per_code[dqs_pkg::REQ_PUSH_FRONT], sent_per_code[dqs_pkg::REQ_PUSH_BACK],
                 sent_per_code[dqs_pkg::REQ_POP_FRONT], sent_per_code[dqs_pkg::REQ_POP_BACK],
                 "search", sent_per_code[dqs_pkg::REQ_SEARCH]);
        $display("Results checked: %0d (ok %0d, full %0d, empty %0d, not found %0d), errors %0d",
                 checked_count, status_hits[dqs_pkg::ST_OK], status_hits[dqs_pkg::ST_FULL],
                 status_hits[dqs_pkg::ST_EMPTY], status_hits[dqs_pkg::ST_NOT_FOUND],
                 fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("double_ended_queue_with_search regression: pass");
        else
            $display("double_ended_queue_with_search regression: fail");
        $finish;
    end

endmodule
